/* src/triplet_average_pattern_classifier_assert.svh */
// assertion macros for the triplet average pattern classifier
`ifndef TRIPLET_AVERAGE_PATTERN_CLASSIFIER_ASSERT_SVH
`define TRIPLET_AVERAGE_PATTERN_CLASSIFIER_ASSERT_SVH
`ifndef SYNTH
`define TAPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TAPC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TAPC_ASSERT_IMP(label, clk, rst, ante, cons)
`define TAPC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/tapc_pkg.sv */
// shared types and constants for the triplet average pattern classifier
`default_nettype none
package tapc_pkg;
  localparam int unsigned MaxTriplets = 16;
  localparam int unsigned SumW = 12;
  localparam logic [1:0] MODEL_19 = 2'd1;
  localparam logic [1:0] MODEL_103 = 2'd2;
  localparam logic [0:0] CFG_MODEL = 1'b0;
  localparam logic [0:0] CFG_COUNT = 1'b1;

  // completed pixel handed from front to back
  typedef struct packed {
    logic [SumW-1:0] a;
    logic [SumW-1:0] f;
    logic [SumW-1:0] d;
    logic [8:0]      n;
    logic [1:0]      model;
  } pix_t;

  function automatic logic [7:0] hi_code(input logic [3:0] r, input logic [3:0] c);
    logic [7:0] t [0:9][0:8];
    t = '{'{8'd191,8'd71,8'd73,8'd75,8'd132,8'd134,8'd45,8'd43,8'd41},
          '{8'd61,8'd111,8'd114,8'd201,8'd203,8'd205,8'd103,8'd101,8'd0},
          '{8'd63,8'd113,8'd223,8'd225,8'd227,8'd207,8'd104,8'd0,8'd0},
          '{8'd65,8'd221,8'd235,8'd236,8'd229,8'd209,8'd0,8'd0,8'd0},
          '{8'd154,8'd219,8'd233,8'd231,8'd211,8'd0,8'd0,8'd0,8'd0},
          '{8'd152,8'd217,8'd215,8'd213,8'd0,8'd0,8'd0,8'd0,8'd0},
          '{8'd95,8'd124,8'd123,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
          '{8'd93,8'd121,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
          '{8'd91,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
          '{8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0}};
    if (r > 4'd9 || c > 4'd8) return 8'd0;
    return t[r][c];
  endfunction

  function automatic logic [7:0] lo_code(input logic [3:0] r, input logic [3:0] c);
    logic [7:0] t [0:9][0:8];
    t = '{'{8'd192,8'd72,8'd74,8'd131,8'd133,8'd135,8'd44,8'd42,8'd182},
          '{8'd62,8'd112,8'd200,8'd202,8'd204,8'd206,8'd102,8'd52,8'd0},
          '{8'd64,8'd222,8'd224,8'd226,8'd228,8'd208,8'd54,8'd0,8'd0},
          '{8'd155,8'd220,8'd234,8'd230,8'd210,8'd141,8'd0,8'd0,8'd0},
          '{8'd153,8'd218,8'd232,8'd212,8'd143,8'd0,8'd0,8'd0,8'd0},
          '{8'd151,8'd216,8'd214,8'd145,8'd0,8'd0,8'd0,8'd0,8'd0},
          '{8'd94,8'd122,8'd84,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
          '{8'd92,8'd82,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
          '{8'd172,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
          '{8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0}};
    if (r > 4'd9 || c > 4'd8) return 8'd0;
    return t[r][c];
  endfunction

  function automatic logic [7:0] row_default(input logic [3:0] r);
    case (r)
      4'd0: return 8'd181;
      4'd1: return 8'd51;
      4'd2: return 8'd53;
      4'd3: return 8'd55;
      4'd4: return 8'd142;
      4'd5: return 8'd144;
      4'd6: return 8'd85;
      4'd7: return 8'd83;
      4'd8: return 8'd81;
      default: return 8'd171;
    endcase
  endfunction
endpackage
`default_nettype wire

/* src/tapc_front.sv */
// front end: accumulates triplets and emits completed pixel sums
`default_nettype none
module tapc_front import tapc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] share_agr,
  input  wire logic [7:0] share_for,
  input  wire logic [7:0] share_dev,
  input  wire logic [1:0] model,
  input  wire logic [4:0] count,
  output logic            done,
  output pix_t            pix
);
  logic [SumW-1:0] sum_a, sum_f, sum_d;
  logic [SumW-1:0] na, nf, nd;
  logic [8:0] seen, seen_next, n_eff;
  localparam logic [8:0] MaxN = 9'(MaxTriplets);

  always_comb begin
    if (count == 5'd0) n_eff = 9'd1;
    else if (9'(count) > MaxN) n_eff = MaxN;
    else n_eff = 9'(count);
    na = sum_a + SumW'(share_agr);
    nf = sum_f + SumW'(share_for);
    nd = sum_d + SumW'(share_dev);
    seen_next = seen + 9'd1;
  end

  assign done = take && (seen_next >= n_eff);
  assign pix = '{a: na, f: nf, d: nd, n: n_eff, model: model};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a <= '0; sum_f <= '0; sum_d <= '0; seen <= '0;
    end else if (take) begin
      if (done) begin
        sum_a <= '0; sum_f <= '0; sum_d <= '0; seen <= '0;
      end else begin
        sum_a <= na; sum_f <= nf; sum_d <= nd; seen <= seen_next;
      end
    end
  end
endmodule
`default_nettype wire

/* src/tapc_queue.sv */
// short queue of completed pixels between front and back
`default_nettype none
module tapc_queue import tapc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire pix_t wdata,
  output logic      full,
  input  wire logic rd,
  output logic      avail,
  output pix_t      rdata
);
  pix_t mem [0:1];
  logic [1:0] cnt;
  logic wp, rp;

  assign full = (cnt == 2'd2);
  assign avail = (cnt != 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; wp <= 1'b0; rp <= 1'b0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

/* src/tapc_back.sv */
// back end: threshold compares (registered) then decision trees into output register
`default_nettype none
module tapc_back import tapc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic avail,
  input  wire pix_t pix,
  output logic      rd,
  output logic      out_valid,
  output logic [7:0] out_code,
  input  wire logic out_take
);
  `include "triplet_average_pattern_classifier_assert.svh"

  // stage 1: compare flags
  logic       s1_valid;
  logic [9:0] s1_ga, s1_gf, s1_gd; // avg >= k/10 for k=1..9 in bits 1..9
  logic       s1_fa, s1_ff, s1_fd, s1_dga, s1_dgf, s1_fga;
  logic [1:0] s1_model;
  logic [9:0] ga, gf, gd;
  logic [15:0] ten_a, ten_f, ten_d;
  logic [16:0] full_v;
  logic s1_ready, s1_load, out_ready;

  always_comb begin
    ten_a = 16'(pix.a) * 16'd10;
    ten_f = 16'(pix.f) * 16'd10;
    ten_d = 16'(pix.d) * 16'd10;
    ga = '0; gf = '0; gd = '0;
    for (int k = 1; k <= 9; k++) begin
      ga[k] = ten_a >= 16'(pix.n * 16'(10 + 254 * k));
      gf[k] = ten_f >= 16'(pix.n * 16'(10 + 254 * k));
      gd[k] = ten_d >= 16'(pix.n * 16'(10 + 254 * k));
    end
    full_v = 17'(pix.n) * 17'd255;
  end

  assign out_ready = !out_valid || out_take;
  assign s1_ready = !s1_valid || out_ready;
  assign s1_load = avail && s1_ready;
  assign rd = s1_load;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (s1_ready) s1_valid <= avail;
    if (s1_load) begin
      s1_ga <= ga; s1_gf <= gf; s1_gd <= gd;
      s1_fa <= 17'(pix.a) == full_v;
      s1_ff <= 17'(pix.f) == full_v;
      s1_fd <= 17'(pix.d) == full_v;
      s1_dga <= pix.d > pix.a;
      s1_dgf <= pix.d > pix.f;
      s1_fga <= pix.f > pix.a;
      s1_model <= pix.model;
    end
  end

  // stage 2: decision trees
  logic [7:0] c19, c103, code;
  logic [3:0] fr, ar;
  logic       afound;
  logic [3:0] dk;

  always_comb begin
    logic a1, f1, d1;
    a1 = s1_ga[1]; f1 = s1_gf[1]; d1 = s1_gd[1];
    if (s1_gf[6]) begin
      if (s1_ff) c19 = 8'd17;
      else if (s1_dga) c19 = a1 ? 8'd12 : (d1 ? 8'd9 : 8'd3);
      else c19 = d1 ? 8'd12 : (a1 ? 8'd8 : 8'd3);
    end else if (s1_ga[6]) begin
      if (s1_fa) c19 = 8'd18;
      else if (s1_dgf) c19 = f1 ? 8'd10 : (d1 ? 8'd4 : 8'd1);
      else c19 = d1 ? 8'd10 : (f1 ? 8'd5 : 8'd1);
    end else if (s1_gd[6]) begin
      if (s1_fd) c19 = 8'd19;
      else if (s1_fga) c19 = a1 ? 8'd11 : (f1 ? 8'd6 : 8'd2);
      else c19 = f1 ? 8'd11 : (a1 ? 8'd7 : 8'd2);
    end else if (!a1) c19 = 8'd15;
    else if (d1) c19 = f1 ? 8'd16 : 8'd13;
    else if (f1) c19 = 8'd14;
    else c19 = 8'd0;

    // thresholds are monotone, so counting set bits gives the level
    fr = 4'($countones(s1_gf[9:1]));
    ar = 4'($countones(s1_ga[9:1]));
    // both levels can reach nine, so the sum needs a fifth bit
    afound = (5'(ar) + 5'(fr)) < 5'd9;
    dk = 4'd9 - fr - ar;
    if (s1_ff) c103 = 8'd170;
    else if (s1_fd) c103 = 8'd190;
    else if (s1_fa) c103 = 8'd180;
    else if (!afound) c103 = row_default(fr);
    else if (s1_gd[dk]) c103 = hi_code(fr, ar);
    else c103 = lo_code(fr, ar);

    unique case (s1_model)
      MODEL_19:  code = c19;
      MODEL_103: code = c103;
      default:   code = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_ready) out_valid <= s1_valid;
    if (out_ready && s1_valid) out_code <= code;
  end

  `TAPC_ASSERT_IMP(a_rd_avail, clk, rst, rd, avail)
  `TAPC_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_take, out_valid && $stable(out_code))
  `TAPC_ASSERT_NXT(a_fill, clk, rst, s1_valid && s1_ready, out_valid)
endmodule
`default_nettype wire

/* src/triplet_average_pattern_classifier.sv */
// triplet average pattern classifier top level
// throughput: one triplet per cycle unless the queue is full, one word per completed pixel
// path: last triplet of a pixel to pattern word on the result ports goes through
//   the pixel queue, the compare stage and the tree stage into the output register
// reset: sums, counts, queue and output cleared; model_select and triplet_count return to 1
`default_nettype none
module triplet_average_pattern_classifier import tapc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] share_agr,
  input  wire logic [7:0] share_for,
  input  wire logic [7:0] share_dev,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      pattern_code,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [4:0] cfg_data
);
  `include "triplet_average_pattern_classifier_assert.svh"

  // configuration registers
  logic [1:0] model_select;
  logic [4:0] triplet_count;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_select <= MODEL_19;
      triplet_count <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODEL: model_select <= cfg_data[1:0];
        CFG_COUNT: triplet_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accumulates a word per cycle while the queue is not full, pushes finished pixels
  logic take, done, q_full, q_avail, q_rd, out_valid;
  pix_t f_pix, q_pix;
  assign full = q_full;
  assign take = push && !q_full;

  tapc_front u_front (
    .clk, .rst, .take, .share_agr, .share_for, .share_dev,
    .model(model_select), .count(triplet_count), .done, .pix(f_pix)
  );

  // queue lets the accumulator run while the back end stalls
  tapc_queue u_queue (
    .clk, .rst, .wr(done), .wdata(f_pix), .full(q_full),
    .rd(q_rd), .avail(q_avail), .rdata(q_pix)
  );

  // back: compare stage then tree stage into the result register
  tapc_back u_back (
    .clk, .rst, .avail(q_avail), .pix(q_pix), .rd(q_rd),
    .out_valid, .out_code(pattern_code), .out_take(pop)
  );

  assign empty = !out_valid;

  `TAPC_ASSERT_IMP(a_no_push_full, clk, rst, full, !take)
  `TAPC_ASSERT_NXT(a_model_rst, clk, 1'b0, rst, model_select == MODEL_19)
  `TAPC_ASSERT_NXT(a_pop_moves, clk, rst, !empty && !pop, !empty)
endmodule
`default_nettype wire

/* tb/sv/triplet_average_pattern_classifier_test.sv */
// self-checking testbench for the triplet average pattern classifier
`default_nettype none
module triplet_average_pattern_classifier_test;
  import tapc_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomWords = 1800;
  // margin for the pipeline to drain after the last triplet
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldOffCycles = 300;

  // class codes of the 103-class tree, indexed by forest row and agriculture column
  localparam logic [7:0] DEV_HIGH_CODE [0:9][0:8] = '{
    '{8'd191, 8'd71, 8'd73, 8'd75, 8'd132, 8'd134, 8'd45, 8'd43, 8'd41},
    '{8'd61, 8'd111, 8'd114, 8'd201, 8'd203, 8'd205, 8'd103, 8'd101, 8'd0},
    '{8'd63, 8'd113, 8'd223, 8'd225, 8'd227, 8'd207, 8'd104, 8'd0, 8'd0},
    '{8'd65, 8'd221, 8'd235, 8'd236, 8'd229, 8'd209, 8'd0, 8'd0, 8'd0},
    '{8'd154, 8'd219, 8'd233, 8'd231, 8'd211, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd152, 8'd217, 8'd215, 8'd213, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd95, 8'd124, 8'd123, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd93, 8'd121, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd91, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}};
  localparam logic [7:0] DEV_LOW_CODE [0:9][0:8] = '{
    '{8'd192, 8'd72, 8'd74, 8'd131, 8'd133, 8'd135, 8'd44, 8'd42, 8'd182},
    '{8'd62, 8'd112, 8'd200, 8'd202, 8'd204, 8'd206, 8'd102, 8'd52, 8'd0},
    '{8'd64, 8'd222, 8'd224, 8'd226, 8'd228, 8'd208, 8'd54, 8'd0, 8'd0},
    '{8'd155, 8'd220, 8'd234, 8'd230, 8'd210, 8'd141, 8'd0, 8'd0, 8'd0},
    '{8'd153, 8'd218, 8'd232, 8'd212, 8'd143, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd151, 8'd216, 8'd214, 8'd145, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd94, 8'd122, 8'd84, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd92, 8'd82, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd172, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}};
  localparam logic [7:0] ROW_FALLBACK_CODE [0:9] = '{
    8'd181, 8'd51, 8'd53, 8'd55, 8'd142, 8'd144, 8'd85, 8'd83, 8'd81, 8'd171};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] share_agr = '0;
  logic [7:0] share_for = '0;
  logic [7:0] share_dev = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] pattern_code;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  triplet_average_pattern_classifier dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .share_agr(share_agr), .share_for(share_for), .share_dev(share_dev),
    .empty(empty), .pop(pop), .pattern_code(pattern_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: our own copy of registers and per-pixel sums
  logic [1:0]  model_sel = MODEL_19;
  logic [4:0]  count_reg = 5'd1;
  int unsigned agr_sum = 0;
  int unsigned for_sum = 0;
  int unsigned dev_sum = 0;
  int unsigned pixel_fill = 0;

  logic [7:0]  pattern_q [$];   // pattern words still owed by the block
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          no_idle = 1'b0;  // stretches with no gaps on either side
  bit          hold_req = 1'b0; // ask the receiver for one long hold-off

  // average >= k/10, exact over the integer sums
  function automatic bit reaches_tenths(int unsigned s, int unsigned n, int unsigned k);
    return 10 * s >= n * (10 + 254 * k);
  endfunction

  function automatic logic [7:0] tree19_code(int unsigned a, int unsigned f,
                                             int unsigned d, int unsigned n);
    bit a1, f1, d1;
    a1 = reaches_tenths(a, n, 1);
    f1 = reaches_tenths(f, n, 1);
    d1 = reaches_tenths(d, n, 1);
    // forest, agriculture, developed matrices in that priority
    if (reaches_tenths(f, n, 6)) begin
      if (f == 255 * n) return 8'd17;
      if (d > a) begin
        if (a1) return 8'd12;
        if (d1) return 8'd9;
      end else begin
        if (d1) return 8'd12;
        if (a1) return 8'd8;
      end
      return 8'd3;
    end
    if (reaches_tenths(a, n, 6)) begin
      if (a == 255 * n) return 8'd18;
      if (d > f) begin
        if (f1) return 8'd10;
        if (d1) return 8'd4;
      end else begin
        if (d1) return 8'd10;
        if (f1) return 8'd5;
      end
      return 8'd1;
    end
    if (reaches_tenths(d, n, 6)) begin
      if (d == 255 * n) return 8'd19;
      if (f > a) begin
        if (a1) return 8'd11;
        if (f1) return 8'd6;
      end else begin
        if (f1) return 8'd11;
        if (a1) return 8'd7;
      end
      return 8'd2;
    end
    if (!a1) return 8'd15;
    if (d1) return f1 ? 8'd16 : 8'd13;
    if (f1) return 8'd14;
    return 8'd0; // agriculture only, no matrix: unclassified
  endfunction

  function automatic logic [7:0] tree103_code(int unsigned a, int unsigned f,
                                              int unsigned d, int unsigned n);
    int unsigned fr, ar;
    if (f == 255 * n) return 8'd170;
    if (d == 255 * n) return 8'd190;
    if (a == 255 * n) return 8'd180;
    fr = 0;
    while (fr < 9 && reaches_tenths(f, n, fr + 1)) fr++;
    for (ar = 0; ar + fr < 9; ar++) begin
      if (!reaches_tenths(a, n, ar + 1))
        return reaches_tenths(d, n, 9 - fr - ar) ? DEV_HIGH_CODE[fr][ar] : DEV_LOW_CODE[fr][ar];
    end
    return ROW_FALLBACK_CODE[fr];
  endfunction

  // fold one accepted triplet in; returns 1 and the code when the pixel completes
  function automatic bit fold_triplet(logic [7:0] a, logic [7:0] f, logic [7:0] d,
                                      output logic [7:0] code);
    int unsigned n;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    agr_sum += a;
    for_sum += f;
    dev_sum += d;
    pixel_fill++;
    code = '0;
    if (pixel_fill < n) return 1'b0;
    if (model_sel == MODEL_19) code = tree19_code(agr_sum, for_sum, dev_sum, n);
    else if (model_sel == MODEL_103) code = tree103_code(agr_sum, for_sum, dev_sum, n);
    agr_sum = 0;
    for_sum = 0;
    dev_sum = 0;
    pixel_fill = 0;
    return 1'b1;
  endfunction

  // offer one triplet; typed_code overrides the predicted word when use_typed is set
  task automatic send_triplet(logic [7:0] a, logic [7:0] f, logic [7:0] d,
                              bit use_typed, logic [7:0] typed_code);
    int unsigned gap;
    logic [7:0]  code;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    share_agr <= a;
    share_for <= f;
    share_dev <= d;
    do @(posedge clk); while (full);
    if (fold_triplet(a, f, d, code)) pattern_q.push_back(use_typed ? typed_code : code);
  endtask

  // registers change only with nothing owed and the pipeline drained
  task automatic write_reg(logic [0:0] idx, logic [4:0] value);
    @(negedge clk);
    push <= 1'b0;
    while (pattern_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MODEL) model_sel = value[1:0];
    else count_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // share level near a tenth boundary, at an extreme, or anywhere
  function automatic logic [7:0] pick_level();
    int unsigned k, v;
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3, 4, 5: begin
        k = $urandom_range(1, 9);
        v = (254 * k + 19) / 10 + $urandom_range(0, 2);
        return 8'(v - 1);
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HoldOffCycles;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  // compare every accepted pattern word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pattern_q.size() == 0) begin
        $error("pattern_code: no word expected, actual %0d", pattern_code);
        mismatches++;
      end else begin
        if (pattern_code !== pattern_q[0]) begin
          $error("pattern_code: expected %0d, actual %0d", pattern_q[0], pattern_code);
          mismatches++;
        end
        void'(pattern_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  typedef struct {
    logic [1:0] model;
    logic [4:0] count;
    logic [7:0] a;
    logic [7:0] f;
    logic [7:0] d;
    bit         typed;
    logic [7:0] code;
  } stim_row_t;

  // directed rows: extremes, branches of both trees and the odd cases
  localparam int NumRows = 25;
  stim_row_t rows [NumRows] = '{
    '{MODEL_19, 5'd1, 8'd1, 8'd1, 8'd1, 1'b1, 8'd15},     // all shares zero
    '{MODEL_19, 5'd1, 8'd0, 8'd0, 8'd0, 1'b1, 8'd15},     // zero bytes, below zero
    '{MODEL_19, 5'd1, 8'd255, 8'd255, 8'd255, 1'b1, 8'd17},
    '{MODEL_19, 5'd1, 8'd255, 8'd1, 8'd1, 1'b1, 8'd18},
    '{MODEL_19, 5'd1, 8'd1, 8'd1, 8'd255, 1'b1, 8'd19},
    '{MODEL_19, 5'd1, 8'd60, 8'd20, 8'd20, 1'b1, 8'd0},   // agriculture only, unclassified
    '{MODEL_19, 5'd1, 8'd140, 8'd170, 8'd20, 1'b0, 8'd0},
    '{MODEL_19, 5'd1, 8'd20, 8'd170, 8'd140, 1'b0, 8'd0},
    '{MODEL_19, 5'd1, 8'd170, 8'd40, 8'd20, 1'b0, 8'd0},
    '{MODEL_19, 5'd1, 8'd20, 8'd40, 8'd170, 1'b0, 8'd0},
    '{MODEL_19, 5'd1, 8'd40, 8'd20, 8'd170, 1'b0, 8'd0},
    '{MODEL_19, 5'd1, 8'd60, 8'd60, 8'd60, 1'b0, 8'd0},
    '{MODEL_19, 5'd1, 8'd27, 8'd26, 8'd27, 1'b0, 8'd0},   // right at one tenth
    '{MODEL_19, 5'd0, 8'd255, 8'd1, 8'd1, 1'b1, 8'd18},   // zero count acts as one
    '{MODEL_19, 5'd3, 8'd200, 8'd10, 8'd30, 1'b0, 8'd0},
    '{MODEL_19, 5'd3, 8'd90, 8'd50, 8'd100, 1'b0, 8'd0},
    '{MODEL_19, 5'd1, 8'd10, 8'd200, 8'd40, 1'b0, 8'd0},  // count lowered mid-pixel
    '{MODEL_103, 5'd1, 8'd1, 8'd255, 8'd1, 1'b1, 8'd170},
    '{MODEL_103, 5'd1, 8'd255, 8'd1, 8'd1, 1'b1, 8'd180},
    '{MODEL_103, 5'd1, 8'd1, 8'd1, 8'd255, 1'b1, 8'd190},
    '{MODEL_103, 5'd1, 8'd1, 8'd1, 8'd1, 1'b1, 8'd192},
    '{MODEL_103, 5'd1, 8'd0, 8'd0, 8'd0, 1'b1, 8'd192},
    '{MODEL_103, 5'd1, 8'd100, 8'd80, 8'd75, 1'b0, 8'd0},
    '{MODEL_103, 5'd1, 8'd230, 8'd26, 8'd1, 1'b0, 8'd0},
    '{MODEL_103, 5'd1, 8'd80, 8'd160, 8'd18, 1'b0, 8'd0}
  };

  initial begin
    int unsigned sent, phase_words, i;
    logic [4:0]  cnt;
    logic [7:0]  base_a, base_f, base_d;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      if (rows[r].model != model_sel) write_reg(CFG_MODEL, {3'b000, rows[r].model});
      if (rows[r].count != count_reg) write_reg(CFG_COUNT, rows[r].count);
      send_triplet(rows[r].a, rows[r].f, rows[r].d, rows[r].typed, rows[r].code);
    end

    // random phases; the first fills the block behind a long receiver stall
    sent = 0;
    while (sent < RandomWords) begin
      write_reg(CFG_MODEL, {3'b000, ($urandom_range(0, 1) ? MODEL_19 : MODEL_103)});
      case ($urandom_range(0, 9))
        0: cnt = 5'd0;
        1: cnt = 5'd31;     // saturates to sixteen
        2: cnt = 5'd16;
        3, 4, 5: cnt = 5'd1;
        6: cnt = 5'($urandom_range(0, 31));
        default: cnt = 5'($urandom_range(2, 5));
      endcase
      if (sent == 0) cnt = 5'd1;
      write_reg(CFG_COUNT, cnt);
      no_idle = ($urandom_range(0, 3) == 0);
      if (sent == 0) begin
        no_idle = 1'b1;
        hold_req = 1'b1;
      end
      phase_words = (cnt > 5) ? 80 : 150;
      base_a = pick_level();
      base_f = pick_level();
      base_d = pick_level();
      for (i = 0; i < phase_words; i++) begin
        // new pixel levels now and then; most words repeat them, the rest are random
        if ($urandom_range(0, 3) == 0) begin
          base_a = pick_level();
          base_f = pick_level();
          base_d = pick_level();
        end
        if ($urandom_range(0, 6) == 0)
          send_triplet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b0, 8'd0);
        else
          send_triplet(base_a, base_f, base_d, 1'b0, 8'd0);
        sent++;
      end
      no_idle = 1'b0;
    end

    @(negedge clk);
    push <= 1'b0;
    while (pattern_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
